// ----- hdl/dtm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtm_pkg
// shared types, codes and helpers of the dirty tile map marker
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int MAX_TILE_COLUMNS_DEF = 64;
  localparam int MAX_TILE_ROWS_DEF    = 64;
  localparam int TILE_SHIFT_DEF       = 4;

  localparam int OP_W      = 2;
  localparam int PIX_W     = 18;
  localparam int SIZE_W    = 11;
  localparam int GRID_W    = 12;
  localparam int ROW_SEL_W = 6;
  localparam int OUT_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] SURFACE_WIDTH_RST  = 11'd320;
  localparam logic [SIZE_W-1:0] SURFACE_HEIGHT_RST = 11'd240;

  typedef enum logic [OP_W-1:0] {
    OP_MARK     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_MARK_ALL = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic step;
    logic rd_sel;
    logic clear;
    logic set_all;
    logic resp_zero;
    logic resp_read;
  } dtm_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dtm_status_t;

  // floor or ceiling of a signed pixel position divided by the tile size
  function automatic logic signed [PIX_W-1:0] tile_div(logic signed [PIX_W-1:0] v,
                                                       int shift, logic round_up);
    logic signed [PIX_W-1:0] bias;
    logic signed [PIX_W-1:0] sum;
    bias = round_up ? $signed(PIX_W'((1 << shift) - 1)) : '0;
    sum  = v + bias;
    return sum >>> shift;
  endfunction

  // clip a tile edge to [0, lim]
  function automatic logic [PIX_W-1:0] clip_edge(logic signed [PIX_W-1:0] v,
                                                 logic [PIX_W-1:0] lim);
    logic [PIX_W-1:0] res;
    if (v < 0) res = '0;
    else if (v > $signed(lim)) res = lim;
    else res = $unsigned(v);
    return res;
  endfunction

endpackage

// ----- hdl/dtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtm_ctrl
// operation sequencer: decodes commands and steps the row read-modify-write
// ----------------------------------------------------------------------------
module dtm_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dtm_pkg::OP_W-1:0]    in_operation,
  input  dtm_pkg::dtm_status_t        status,
  output dtm_pkg::dtm_cmd_t           cmd,
  output logic                        busy,
  output logic                        out_valid
);
  import dtm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MARK,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op_t'(in_operation))
            OP_MARK: begin
              state_nxt = ST_SETUP;
            end
            OP_CLEAR: begin
              cmd.clear     = 1'b1;
              cmd.resp_zero = 1'b1;
            end
            OP_MARK_ALL: begin
              cmd.set_all   = 1'b1;
              cmd.resp_zero = 1'b1;
            end
            OP_READ: begin
              cmd.rd_sel = 1'b1;
              state_nxt  = ST_READ;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (status.empty) begin
          cmd.resp_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd.step = 1'b1;
        if (status.last) begin
          cmd.resp_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.resp_read = 1'b1;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.resp_zero | cmd.resp_read;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/dtm_dp.sv -----
// ----------------------------------------------------------------------------
// dtm_dp
// datapath: size registers, tile edge math, row memory and result register
// ----------------------------------------------------------------------------
module dtm_dp #(
  parameter int MAX_TILE_COLUMNS = dtm_pkg::MAX_TILE_COLUMNS_DEF,
  parameter int MAX_TILE_ROWS    = dtm_pkg::MAX_TILE_ROWS_DEF,
  parameter int TILE_SHIFT       = dtm_pkg::TILE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [15:0]               in_rect_x,
  input  logic signed [15:0]               in_rect_y,
  input  logic [14:0]                      in_rect_width,
  input  logic [14:0]                      in_rect_height,
  input  logic [dtm_pkg::ROW_SEL_W-1:0]    in_row_select,
  input  logic                             cfg_wr,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtm_pkg::SIZE_W-1:0]       cfg_data,
  input  dtm_pkg::dtm_cmd_t                cmd,
  output dtm_pkg::dtm_status_t             status,
  output logic [dtm_pkg::OUT_W-1:0]        out_row_bits,
  output logic                             out_row_in_range
);
  import dtm_pkg::*;

  localparam int CCW   = $clog2(MAX_TILE_COLUMNS + 1);
  localparam int RCW   = $clog2(MAX_TILE_ROWS + 1);
  localparam int RW    = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
  localparam int SW    = (RCW > ROW_SEL_W) ? RCW : ROW_SEL_W;
  localparam int TMASK = (1 << TILE_SHIFT) - 1;

  logic [SIZE_W-1:0] width_r, height_r;

  // grid size
  logic [GRID_W-1:0] cols_wide, rows_wide;
  logic [CCW-1:0]    cols;
  logic [RCW-1:0]    rows;

  assign cols_wide = (GRID_W'(width_r) + GRID_W'(TMASK)) >> TILE_SHIFT;
  assign rows_wide = (GRID_W'(height_r) + GRID_W'(TMASK)) >> TILE_SHIFT;
  assign cols = (cols_wide > GRID_W'(MAX_TILE_COLUMNS)) ? CCW'(MAX_TILE_COLUMNS)
                                                        : cols_wide[CCW-1:0];
  assign rows = (rows_wide > GRID_W'(MAX_TILE_ROWS)) ? RCW'(MAX_TILE_ROWS)
                                                     : rows_wide[RCW-1:0];

  // tile edges of the rectangle
  logic signed [PIX_W-1:0] xs, ys, xe, ye;
  logic [PIX_W-1:0]        x1_c, x2_c, y1_c, y2_c;

  assign xs = $signed({{(PIX_W-16){in_rect_x[15]}}, in_rect_x});
  assign ys = $signed({{(PIX_W-16){in_rect_y[15]}}, in_rect_y});
  assign xe = xs + $signed(PIX_W'(in_rect_width));
  assign ye = ys + $signed(PIX_W'(in_rect_height));

  assign x1_c = clip_edge(tile_div(xs, TILE_SHIFT, 1'b0), PIX_W'(cols));
  assign x2_c = clip_edge(tile_div(xe, TILE_SHIFT, 1'b1), PIX_W'(cols));
  assign y1_c = clip_edge(tile_div(ys, TILE_SHIFT, 1'b0), PIX_W'(rows));
  assign y2_c = clip_edge(tile_div(ye, TILE_SHIFT, 1'b1), PIX_W'(rows));

  logic [CCW-1:0] x1_r, x2_r;
  logic [RCW-1:0] y1_r, y2_r, row_r, next_row;
  logic [MAX_TILE_COLUMNS-1:0] rect_mask, col_mask;

  always_comb begin
    for (int i = 0; i < MAX_TILE_COLUMNS; i++) begin
      rect_mask[i] = (CCW'(i) >= x1_r) && (CCW'(i) < x2_r);
      col_mask[i]  = (CCW'(i) < cols);
    end
  end

  assign next_row     = row_r + RCW'(1);
  assign status.empty = !((x1_r < x2_r) && (y1_r < y2_r));
  assign status.last  = (next_row == y2_r);

  // row memory, entries without a valid bit read as the fill value
  logic [MAX_TILE_COLUMNS-1:0] mem [MAX_TILE_ROWS];
  logic [MAX_TILE_ROWS-1:0]    valid_r;
  logic                        fill_r;
  logic [MAX_TILE_COLUMNS-1:0] rdata_r, row_val;
  logic                        vld_rd_r, sel_in_r;
  logic [SW-1:0]               sel_ext;
  logic [RW-1:0]               rd_addr, wr_addr;
  logic                        rd_en;

  assign sel_ext = SW'(in_row_select);
  assign wr_addr = row_r[RW-1:0];
  assign rd_en   = cmd.rd_sel | cmd.rd_first | cmd.step;

  always_comb begin
    priority if (cmd.rd_sel) rd_addr = sel_ext[RW-1:0];
    else if (cmd.rd_first)   rd_addr = y1_r[RW-1:0];
    else                     rd_addr = next_row[RW-1:0];
  end

  assign row_val = vld_rd_r ? rdata_r : {MAX_TILE_COLUMNS{fill_r}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SURFACE_WIDTH_RST;
      height_r <= SURFACE_HEIGHT_RST;
      valid_r  <= '0;
      fill_r   <= 1'b1;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SURFACE_WIDTH:  width_r  <= cfg_data;
          REG_SURFACE_HEIGHT: height_r <= cfg_data;
        endcase
      end
      if (cmd.clear) begin
        valid_r <= '0;
        fill_r  <= 1'b0;
      end else if (cmd.set_all) begin
        valid_r <= '0;
        fill_r  <= 1'b1;
      end else if (cmd.step) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r <= x1_c[CCW-1:0];
      x2_r <= x2_c[CCW-1:0];
      y1_r <= y1_c[RCW-1:0];
      y2_r <= y2_c[RCW-1:0];
    end
    if (cmd.rd_first) row_r <= y1_r;
    else if (cmd.step) row_r <= next_row;
    if (cmd.rd_sel) sel_in_r <= (sel_ext < SW'(rows));
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      vld_rd_r <= valid_r[rd_addr];
    end
    if (cmd.step) mem[wr_addr] <= row_val | rect_mask;
    if (cmd.resp_zero) begin
      out_row_bits     <= '0;
      out_row_in_range <= 1'b0;
    end else if (cmd.resp_read) begin
      out_row_bits     <= sel_in_r ? OUT_W'(row_val & col_mask) : '0;
      out_row_in_range <= sel_in_r;
    end
  end

endmodule

// ----- hdl/dirty_tile_map_marker.sv -----
// ----------------------------------------------------------------------------
// dirty_tile_map_marker
// bitmap of dirty tiles of a surface: mark rectangle, clear, mark all, read row
// clear, mark all respond next cycle; read via ST_READ, mark via ST_SETUP/ST_MARK
// mark throughput is one tile row per cycle through the row memory read-modify-write
// busy stays low for clear and mark all, so those can issue every cycle
// sync reset: surface 320x240, every tile dirty; results cannot be stalled
// ----------------------------------------------------------------------------
module dirty_tile_map_marker #(
  parameter int MAX_TILE_COLUMNS = dtm_pkg::MAX_TILE_COLUMNS_DEF,
  parameter int MAX_TILE_ROWS    = dtm_pkg::MAX_TILE_ROWS_DEF,
  parameter int TILE_SHIFT       = dtm_pkg::TILE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dtm_pkg::OP_W-1:0]         in_operation,
  input  logic signed [15:0]               in_rect_x,
  input  logic signed [15:0]               in_rect_y,
  input  logic [14:0]                      in_rect_width,
  input  logic [14:0]                      in_rect_height,
  input  logic [dtm_pkg::ROW_SEL_W-1:0]    in_row_select,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtm_pkg::SIZE_W-1:0]       cfg_data,
  output logic                             out_valid,
  output logic [dtm_pkg::OUT_W-1:0]        out_row_bits,
  output logic                             out_row_in_range
);
  import dtm_pkg::*;

  dtm_cmd_t    cmd;
  dtm_status_t status;

  assign cfg_ready = 1'b1;

  dtm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  dtm_dp #(
    .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
    .MAX_TILE_ROWS    (MAX_TILE_ROWS),
    .TILE_SHIFT       (TILE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_row_select    (in_row_select),
    .cfg_wr           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_row_bits     (out_row_bits),
    .out_row_in_range (out_row_in_range)
  );

endmodule
